[hw/rtl/imfc_pkg.sv]
// ----------------------------------------------------------------------------
// imfc_pkg
// Shared types and constants for the ICMP MTU frame classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package imfc_pkg;

  localparam int unsigned PORT_W = 16;

  localparam logic [3:0] V_FORWARD      = 4'd0;
  localparam logic [3:0] V_RUNT         = 4'd1;
  localparam logic [3:0] V_BCAST_DST    = 4'd2;
  localparam logic [3:0] V_BAD_IHL      = 4'd3;
  localparam logic [3:0] V_BAD_PROTO    = 4'd4;
  localparam logic [3:0] V_SHORT_ICMP   = 4'd5;
  localparam logic [3:0] V_MTU_RANGE    = 4'd6;
  localparam logic [3:0] V_MTU_STRICT   = 4'd7;
  localparam logic [3:0] V_PAY_SHORT    = 4'd8;
  localparam logic [3:0] V_PAY_VERSION  = 4'd9;
  localparam logic [3:0] V_PORT_SHORT   = 4'd10;
  localparam logic [3:0] V_PORT_DENIED  = 4'd11;
  localparam logic [3:0] V_OVERSIZE     = 4'd12;

  localparam logic [1:0] REG_STRICT_MTU  = 2'd0;
  localparam logic [1:0] REG_USE_SRC_MAC = 2'd1;
  localparam logic [1:0] REG_PORT_FILTER = 2'd2;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        data_byte;
    logic              frame_end;
    logic [PORT_W-1:0] port_index;
    logic              port_allowed;
  } item_t;

  typedef struct packed {
    logic strict_mtu;
    logic use_src_mac;
    logic port_filter_enable;
  } cfg_t;

  typedef struct packed {
    logic [3:0]        verdict;
    logic              mtu_present;
    logic [31:0]       mtu_value;
    logic              addr_is_v6;
    logic [63:0]       src_key_high;
    logic [63:0]       src_key_low;
    logic              port_present;
    logic [PORT_W-1:0] l4_source_port;
    logic [47:0]       new_src_mac;
    logic [11:0]       frame_length;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/imfc_ifs.sv]
// ----------------------------------------------------------------------------
// imfc channel interfaces
// Valid/ready channels for input items and verdict items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface imfc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  data_byte;
  logic        frame_end;
  logic [15:0] port_index;
  logic        port_allowed;
  modport source (output valid, req_type, data_byte, frame_end, port_index, port_allowed,
                  input ready);
  modport sink (input valid, req_type, data_byte, frame_end, port_index, port_allowed,
                output ready);
endinterface

interface imfc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic        mtu_present;
  logic [31:0] mtu_value;
  logic        addr_is_v6;
  logic [63:0] src_key_high;
  logic [63:0] src_key_low;
  logic        port_present;
  logic [15:0] l4_source_port;
  logic [47:0] new_src_mac;
  logic [11:0] frame_length;
  modport source (output valid, verdict, mtu_present, mtu_value, addr_is_v6, src_key_high,
                  src_key_low, port_present, l4_source_port, new_src_mac, frame_length,
                  input ready);
  modport sink (input valid, verdict, mtu_present, mtu_value, addr_is_v6, src_key_high,
                src_key_low, port_present, l4_source_port, new_src_mac, frame_length,
                output ready);
endinterface
`default_nettype wire

[hw/rtl/imfc_allow_table.sv]
// ----------------------------------------------------------------------------
// imfc_allow_table
// One-bit port allow memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module imfc_allow_table (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [imfc_pkg::PORT_W-1:0] wr_addr,
  input  wire logic                       wr_data,
  input  wire logic                       rd_en,
  input  wire logic [imfc_pkg::PORT_W-1:0] rd_addr,
  output logic                            rd_data,
  output logic                            busy
);
  import imfc_pkg::*;

  logic              mem [0:(1 << PORT_W)-1];
  logic [PORT_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {PORT_W{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/imfc_parse.sv]
// ----------------------------------------------------------------------------
// imfc_parse
// Per-byte header capture and end-of-frame verdict logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module imfc_parse #(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        frame_end,
  input  wire imfc_pkg::cfg_t              cfg,
  output imfc_pkg::result_t                judge,
  output logic                             need_check,
  output logic [imfc_pkg::PORT_W-1:0]      lookup_port
);
  import imfc_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_FRAME + 1);

  logic [POS_W-1:0] pos, pos_next;
  logic             ovf, ovf_next;
  logic [47:0]      dst, dst_next, src, src_next;
  logic [15:0]      et, et_next;
  logic             vlan, vlan_next;
  logic [7:0]       vih, vih_next, proto, proto_next, pfb, pfb_next;
  logic [63:0]      sa0, sa0_next, sa1, sa1_next;
  logic [15:0]      itc, itc_next, port, port_next;
  logic [31:0]      mtu, mtu_next;

  logic [15:0] p, l3, ic, l4, len, l3j, hlj, icj, payj, l4j;
  logic [7:0]  b;
  logic        v4, v6, v4j, v6j, addr_ok, mtu_p;
  logic [31:0] mtu_j;
  logic [3:0]  verdict;

  assign b = data_byte;
  assign p = 16'(pos);

  // capture of the current byte
  always_comb begin
    pos_next   = pos;
    ovf_next   = ovf;
    dst_next   = dst;
    src_next   = src;
    et_next    = et;
    vlan_next  = vlan;
    vih_next   = vih;
    proto_next = proto;
    sa0_next   = sa0;
    sa1_next   = sa1;
    itc_next   = itc;
    mtu_next   = mtu;
    pfb_next   = pfb;
    port_next  = port;
    l3 = vlan ? 16'd18 : 16'd14;
    v4 = (et == 16'h0800) && (vih[7:4] == 4'h4);
    v6 = (et == 16'h86dd) && (vih[7:4] == 4'h6);
    ic = '0;
    if (v4) begin
      ic = ({12'd0, vih[3:0]} < 16'd5) ? 16'd0 : l3 + {10'd0, vih[3:0], 2'b00};
    end else if (v6) begin
      ic = l3 + 16'd40;
    end
    l4 = '0;
    if (pos < POS_W'(MAX_FRAME)) begin
      pos_next = pos + 1'b1;
      if (p < 16'd6) begin
        dst_next = {dst[39:0], b};
      end else if (p < 16'd12) begin
        src_next = {src[39:0], b};
      end else if (p < 16'd14) begin
        et_next = {et[7:0], b};
        if (p == 16'd13) begin
          vlan_next = ({et[7:0], b} == 16'h8100);
        end
      end else if ((p == 16'd16 || p == 16'd17) && vlan) begin
        et_next = {et[7:0], b};
      end
      if (p >= 16'd14) begin
        if (p == l3) begin
          vih_next = b;
        end
        if (p > l3) begin
          if (v4) begin
            if (p == l3 + 16'd9) proto_next = b;
            if (p >= l3 + 16'd12 && p < l3 + 16'd16) sa1_next = {32'd0, sa1[23:0], b};
          end else if (v6) begin
            if (p == l3 + 16'd6) proto_next = b;
            if (p >= l3 + 16'd8 && p < l3 + 16'd16) sa0_next = {sa0[55:0], b};
            if (p >= l3 + 16'd16 && p < l3 + 16'd24) sa1_next = {sa1[55:0], b};
          end
          if (ic != 16'd0 && p >= ic) begin
            if (p < ic + 16'd2) begin
              itc_next = {itc[7:0], b};
            end else if (p >= ic + 16'd4 && p < ic + 16'd8) begin
              mtu_next = {mtu[23:0], b};
            end
            if (p == ic + 16'd8) pfb_next = b;
            if (p >= ic + 16'd8) begin
              if (pfb_next[7:4] == 4'h4) begin
                l4 = ic + 16'd8 + {10'd0, pfb_next[3:0], 2'b00};
              end else if (pfb_next[7:4] == 4'h6) begin
                l4 = ic + 16'd48;
              end
              if (l4 != 16'd0 && (p == l4 || p == l4 + 16'd1)) begin
                port_next = {port[7:0], b};
              end
            end
          end
        end
      end
    end else begin
      ovf_next = 1'b1;
    end
  end

  // verdict on the state after this byte
  always_comb begin
    len     = 16'(pos_next);
    l3j     = vlan_next ? 16'd18 : 16'd14;
    hlj     = {10'd0, vih_next[3:0], 2'b00};
    v4j     = (et_next == 16'h0800) && (vih_next[7:4] == 4'h4);
    v6j     = (et_next == 16'h86dd) && (vih_next[7:4] == 4'h6);
    icj     = v4j ? l3j + hlj : l3j + 16'd40;
    payj    = icj + 16'd8;
    l4j     = '0;
    addr_ok = 1'b0;
    mtu_p   = 1'b0;
    mtu_j   = '0;
    verdict = V_FORWARD;
    judge   = '0;
    need_check = 1'b0;
    judge.frame_length = len[11:0];
    if (ovf_next) begin
      verdict = V_OVERSIZE;
    end else if (len < 16'd50) begin
      verdict = V_RUNT;
    end else if (dst_next == 48'hffff_ffff_ffff) begin
      verdict = V_BCAST_DST;
    end else if (v4j && hlj < 16'd20) begin
      verdict = V_BAD_IHL;
    end else begin
      if (v4j) addr_ok = (proto_next == 8'd1) && (len >= l3j + 16'd56);
      if (v6j) addr_ok = (proto_next == 8'd58) && (len >= l3j + 16'd80);
      if (!addr_ok) begin
        verdict = V_BAD_PROTO;
      end else begin
        judge.addr_is_v6   = v6j;
        judge.src_key_high = v6j ? sa0_next : 64'd0;
        judge.src_key_low  = sa1_next;
        if (len < payj) begin
          verdict = V_SHORT_ICMP;
        end else begin
          if (v4j && itc_next == 16'h0304) begin
            mtu_p = 1'b1;
            mtu_j = {16'd0, mtu_next[15:0]};
          end
          if (v6j && itc_next == 16'h0200) begin
            mtu_p = 1'b1;
            mtu_j = mtu_next;
          end
          judge.mtu_present = mtu_p;
          judge.mtu_value   = mtu_j;
          if (mtu_p && (mtu_j < 32'd68 || mtu_j > 32'd16384)) begin
            verdict = V_MTU_RANGE;
          end else if (mtu_p && cfg.strict_mtu && (mtu_j < 32'd576 || mtu_j >= 32'd1500)) begin
            verdict = V_MTU_STRICT;
          end else if (cfg.port_filter_enable) begin
            if (pfb_next[7:4] == 4'h4) begin
              l4j = payj + {10'd0, pfb_next[3:0], 2'b00};
            end else if (pfb_next[7:4] == 4'h6) begin
              l4j = payj + 16'd40;
            end
            if (len < payj + 16'd1) begin
              verdict = V_PAY_SHORT;
            end else if (l4j == 16'd0) begin
              verdict = V_PAY_VERSION;
            end else if (len < l4j + 16'd2) begin
              verdict = V_PORT_SHORT;
            end else begin
              judge.port_present   = 1'b1;
              judge.l4_source_port = port_next;
              need_check           = 1'b1;
            end
          end
        end
      end
    end
    judge.verdict = verdict;
    if (verdict == V_FORWARD) begin
      judge.new_src_mac = cfg.use_src_mac ? src_next : dst_next;
    end
  end

  assign lookup_port = port_next;

  always_ff @(posedge clk) begin
    if (rst || (en && frame_end)) begin
      pos   <= '0;
      ovf   <= 1'b0;
      dst   <= '0;
      src   <= '0;
      et    <= '0;
      vlan  <= 1'b0;
      vih   <= '0;
      proto <= '0;
      sa0   <= '0;
      sa1   <= '0;
      itc   <= '0;
      mtu   <= '0;
      pfb   <= '0;
      port  <= '0;
    end else if (en) begin
      pos   <= pos_next;
      ovf   <= ovf_next;
      dst   <= dst_next;
      src   <= src_next;
      et    <= et_next;
      vlan  <= vlan_next;
      vih   <= vih_next;
      proto <= proto_next;
      sa0   <= sa0_next;
      sa1   <= sa1_next;
      itc   <= itc_next;
      mtu   <= mtu_next;
      pfb   <= pfb_next;
      port  <= port_next;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/icmp_mtu_frame_classifier_core.sv]
// ----------------------------------------------------------------------------
// icmp_mtu_frame_classifier_core
// Classifies ICMP packet-too-big frames byte by byte and gives one verdict
// per frame.
// ----------------------------------------------------------------------------
// One item is taken every cycle while the verdict channel does not stall. A
// frame's verdict passes the input register, the capture and table read, and
// the result register after its last byte is taken. After reset the port allow
// memory is cleared one entry a cycle, all 65536 entries, during which no item
// is taken; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module icmp_mtu_frame_classifier_core #(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  wire logic       clk,
  input  wire logic       rst,
  imfc_in_if.sink         ingress,
  imfc_out_if.source      egress,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic       cfg_data
);
  import imfc_pkg::*;

  cfg_t    cfg;
  item_t   s0;
  logic    v0, v1, v2, en0, en1, en2, go0, busy, is_byte;
  result_t judge, s1, s2, s2_next;
  logic    need_check, s1_check, allowed;
  logic [PORT_W-1:0] lookup_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRICT_MTU:  cfg.strict_mtu         <= cfg_data;
        REG_USE_SRC_MAC: cfg.use_src_mac        <= cfg_data;
        REG_PORT_FILTER: cfg.port_filter_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en2 = !v2 || egress.ready;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign go0 = v0 && en1;
  assign is_byte = (s0.req_type == REQ_BYTE);
  assign ingress.ready = en0 && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= ingress.valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s0.req_type     <= ingress.req_type;
      s0.data_byte    <= ingress.data_byte;
      s0.frame_end    <= ingress.frame_end;
      s0.port_index   <= ingress.port_index;
      s0.port_allowed <= ingress.port_allowed;
    end
  end

  imfc_parse #(.MAX_FRAME(MAX_FRAME)) u_parse (
    .clk         (clk),
    .rst         (rst),
    .en          (go0 && is_byte),
    .data_byte   (s0.data_byte),
    .frame_end   (s0.frame_end),
    .cfg         (cfg),
    .judge       (judge),
    .need_check  (need_check),
    .lookup_port (lookup_port)
  );

  imfc_allow_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (go0 && !is_byte),
    .wr_addr (s0.port_index),
    .wr_data (s0.port_allowed),
    .rd_en   (go0 && is_byte),
    .rd_addr (lookup_port),
    .rd_data (allowed),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= go0 && is_byte && s0.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1       <= judge;
      s1_check <= need_check;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  // port denial once the table bit is back
  always_comb begin
    s2_next = s1;
    if (s1_check && !allowed) begin
      s2_next.verdict     = V_PORT_DENIED;
      s2_next.new_src_mac = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2 <= s2_next;
    end
  end

  assign egress.valid          = v2;
  assign egress.verdict        = s2.verdict;
  assign egress.mtu_present    = s2.mtu_present;
  assign egress.mtu_value      = s2.mtu_value;
  assign egress.addr_is_v6     = s2.addr_is_v6;
  assign egress.src_key_high   = s2.src_key_high;
  assign egress.src_key_low    = s2.src_key_low;
  assign egress.port_present   = s2.port_present;
  assign egress.l4_source_port = s2.l4_source_port;
  assign egress.new_src_mac    = s2.new_src_mac;
  assign egress.frame_length   = s2.frame_length;
endmodule
`default_nettype wire

[hw/rtl/imfc_checker.sv]
// ----------------------------------------------------------------------------
// imfc_checker
// Port-level checks on the verdict channel of the classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module imfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  verdict,
  input wire logic        mtu_present,
  input wire logic [31:0] mtu_value,
  input wire logic        port_present,
  input wire logic [15:0] l4_source_port,
  input wire logic [47:0] new_src_mac
);
  import imfc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("item dropped or changed while stalled");

  a_mac: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != V_FORWARD |-> new_src_mac == 48'd0)
    else $error("mac on rejected frame");

  a_mtu: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mtu_present |-> mtu_value == 32'd0)
    else $error("mtu without packet-too-big");

  a_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && port_present |-> verdict == V_FORWARD || verdict == V_PORT_DENIED)
    else $error("port with wrong verdict");

  a_noport: assert property (@(posedge clk) disable iff (rst)
    out_valid && !port_present |-> l4_source_port == 16'd0)
    else $error("port value without port");
endmodule

bind icmp_mtu_frame_classifier_core imfc_checker u_imfc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (egress.valid),
  .out_ready      (egress.ready),
  .verdict        (egress.verdict),
  .mtu_present    (egress.mtu_present),
  .mtu_value      (egress.mtu_value),
  .port_present   (egress.port_present),
  .l4_source_port (egress.l4_source_port),
  .new_src_mac    (egress.new_src_mac)
);
`default_nettype wire
